// ===== src/csplit_pkg.sv =====
// ----------------------------------------------------------------------------
// csplit_pkg: shared types and constants
// Beat layouts, request codes and saturating arithmetic for the route split.
// ----------------------------------------------------------------------------
package csplit_pkg;

	localparam int unsigned NODE_W      = 6;
	localparam int unsigned NODES       = 64;
	localparam int unsigned COST_W      = 24;
	localparam int unsigned CAP_W       = 22;
	localparam int unsigned LOAD_W      = 23;
	localparam int unsigned VAL_W       = 16;
	localparam int unsigned CFG_DATA_W  = 22;
	localparam int unsigned CFG_IDX_W   = 1;
	localparam int unsigned DEF_MAX_CLIENTS = 63;
	localparam int unsigned DEF_DIST_BITS   = 16;

	localparam logic [COST_W-1:0] SAT24 = {COST_W{1'b1}};

	localparam logic [1:0] REQ_DIST   = 2'd0;
	localparam logic [1:0] REQ_DEMAND = 2'd1;
	localparam logic [1:0] REQ_TOUR   = 2'd2;
	localparam logic [1:0] REQ_START  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_CLIENTS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY    = 1'd1;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [NODE_W-1:0] row;
		logic [NODE_W-1:0] col;
		logic [VAL_W-1:0]  value;
	} in_t;

	typedef struct packed {
		logic [NODE_W-1:0] trip_index;
		logic [NODE_W-1:0] first_pos;
		logic [NODE_W-1:0] last_pos;
		logic [COST_W-1:0] trip_cost;
		logic [COST_W-1:0] total_cost;
		logic              is_last;
	} out_t;

	// table read addresses issued by the sequencer
	typedef struct packed {
		logic [2*NODE_W-1:0] dist_ra;
		logic [NODE_W-1:0]   dem_ra;
		logic [NODE_W-1:0]   tour_ra;
	} tbl_rd_t;

	// label / predecessor write port
	typedef struct packed {
		logic              we;
		logic [NODE_W-1:0] addr;
		logic [COST_W-1:0] label;
		logic [NODE_W-1:0] pred;
	} lbl_wr_t;

	function automatic logic [COST_W-1:0] sat_add24(input logic [COST_W-1:0] a,
			input logic [COST_W-1:0] b);
		logic [COST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COST_W] ? SAT24 : s[COST_W-1:0];
	endfunction

endpackage

// ===== src/csplit_tables.sv =====
// ----------------------------------------------------------------------------
// csplit_tables: problem tables
// Distance, demand and giant-tour memories, written by load beats and read
// through registered read ports.
// ----------------------------------------------------------------------------
module csplit_tables import csplit_pkg::*; #(
	parameter int unsigned DIST_BITS = DEF_DIST_BITS
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  in_t                  wr_data,
	input  tbl_rd_t              rd,
	output logic [DIST_BITS-1:0] dist_rd,
	output logic [VAL_W-1:0]     dem_rd,
	output logic [NODE_W-1:0]    tour_rd
);

	logic [DIST_BITS-1:0] dist_mem [NODES*NODES];
	logic [VAL_W-1:0]     dem_mem  [NODES];
	logic [NODE_W-1:0]    tour_mem [NODES];

	always_ff @(posedge clk) begin
		if (wr_en && wr_data.req_type == REQ_DIST) begin
			dist_mem[{wr_data.row, wr_data.col}] <= DIST_BITS'(wr_data.value);
		end
		dist_rd <= dist_mem[rd.dist_ra];
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_data.req_type == REQ_DEMAND) begin
			dem_mem[wr_data.row] <= wr_data.value;
		end
		dem_rd <= dem_mem[rd.dem_ra];
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_data.req_type == REQ_TOUR) begin
			tour_mem[wr_data.row] <= wr_data.value[NODE_W-1:0];
		end
		tour_rd <= tour_mem[rd.tour_ra];
	end

endmodule

// ===== src/csplit_labels.sv =====
// ----------------------------------------------------------------------------
// csplit_labels: shortest-path labels
// Best label and predecessor per tour position, one write and one read port.
// ----------------------------------------------------------------------------
module csplit_labels import csplit_pkg::*; (
	input  logic              clk,
	input  lbl_wr_t           wr,
	input  logic [NODE_W-1:0] ra,
	output logic [COST_W-1:0] label_rd,
	output logic [NODE_W-1:0] pred_rd
);

	logic [COST_W-1:0] label_mem [NODES];
	logic [NODE_W-1:0] pred_mem  [NODES];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			label_mem[wr.addr] <= wr.label;
			pred_mem[wr.addr]  <= wr.pred;
		end
		label_rd <= label_mem[ra];
		pred_rd  <= pred_mem[ra];
	end

endmodule

// ===== src/capacitated_route_split.sv =====
// ----------------------------------------------------------------------------
// capacitated_route_split: split a giant tour into capacitated trips
// Table loading, shortest-path split pass, backtrack and trip emission.
// ----------------------------------------------------------------------------
// Load beats (distance, demand, tour position) are plain memory writes and
// are taken one per cycle while the block is idle. A start beat runs the
// split pass over n tour positions and holds the input stalled until the
// last trip beat is taken. The pass is paced by the single read port of
// each table memory: each start position reads its tour entry, label,
// distance and demand, and each trip candidate takes a compare step and,
// short of the tour end, an extension step. The backtrack reads one label
// per trip, and the emission walk visits each position and emits each
// trip, waiting on output stalls. Trips come out in tour order; every beat
// carries the best total cost, and the final one has is_last set. A start
// with num_clients of zero produces no beat.
// ----------------------------------------------------------------------------
module capacitated_route_split import csplit_pkg::*; #(
	parameter int unsigned MAX_CLIENTS = DEF_MAX_CLIENTS,
	parameter int unsigned DIST_BITS   = DEF_DIST_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned N_LIMIT = (MAX_CLIENTS > NODES - 1) ? NODES - 1 : MAX_CLIENTS;

	typedef enum logic [3:0] {
		S_IDLE, S_OA, S_OB, S_OC, S_EA, S_EB, S_XA, S_XB,
		S_BA, S_BB, S_FA, S_FB, S_FC, S_FD, S_OUT
	} state_t;

	state_t            state_q;
	logic [NODE_W-1:0] num_clients_q;
	logic [CAP_W-1:0]  capacity_q;
	logic [NODE_W-1:0] n_q, i_q, j_q, c_q, nc_q, p_q, pos_q, prev_q, first_q, tidx_q;
	logic [COST_W-1:0] li_q, path_q, pd_q, acc_q, total_q;
	logic [LOAD_W-1:0] load_q;
	logic [NODES-1:0]  reached_q, cut_q;
	logic              tstart_q;
	logic              out_valid_q;
	out_t              out_q;

	logic                 in_acc, start_go;
	logic [NODE_W-1:0]    n_eff;
	tbl_rd_t              tbl_rd;
	logic [DIST_BITS-1:0] dist_rd;
	logic [VAL_W-1:0]     dem_rd;
	logic [NODE_W-1:0]    tour_rd;
	lbl_wr_t              lbl_wr;
	logic [NODE_W-1:0]    lbl_ra;
	logic [COST_W-1:0]    label_rd;
	logic [NODE_W-1:0]    pred_rd;
	logic [COST_W-1:0]    dist_ext, cand;
	logic [LOAD_W-1:0]    load_next;
	logic [NODE_W-1:0]    q_fix;
	logic                 better;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign n_eff     = (num_clients_q > NODE_W'(N_LIMIT)) ? NODE_W'(N_LIMIT) : num_clients_q;
	assign start_go  = in_acc && in_data.req_type == REQ_START && n_eff != '0;
	assign dist_ext  = COST_W'(dist_rd);
	assign cand      = sat_add24(li_q, pd_q);
	assign better    = !reached_q[j_q] || cand < label_rd;
	assign load_next = load_q + LOAD_W'(dem_rd);
	assign q_fix     = (pred_rd >= p_q) ? p_q - 1'b1 : pred_rd;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// read addresses follow the sequencer state; data lands in the next cycle
	always_comb begin
		tbl_rd = '0;
		lbl_ra = '0;
		case (state_q)
			S_OA: begin
				tbl_rd.tour_ra = i_q + 1'b1;
				lbl_ra         = i_q;
			end
			S_OB: begin
				tbl_rd.dist_ra = {{NODE_W{1'b0}}, tour_rd};
				tbl_rd.dem_ra  = tour_rd;
			end
			S_OC: tbl_rd.dist_ra = {c_q, {NODE_W{1'b0}}};
			S_EA: lbl_ra = j_q;
			S_EB: tbl_rd.tour_ra = j_q + 1'b1;
			S_XA: begin
				tbl_rd.dist_ra = {c_q, tour_rd};
				tbl_rd.dem_ra  = tour_rd;
			end
			S_XB: tbl_rd.dist_ra = {nc_q, {NODE_W{1'b0}}};
			S_BA: lbl_ra = p_q;
			S_FA: tbl_rd.tour_ra = pos_q;
			S_FB: tbl_rd.dist_ra = tstart_q ? {{NODE_W{1'b0}}, tour_rd} : {prev_q, tour_rd};
			S_FC: tbl_rd.dist_ra = {c_q, {NODE_W{1'b0}}};
			default: ;
		endcase
	end

	// label writes: seed position zero at start, improve a position on compare
	always_comb begin
		lbl_wr = '0;
		if (state_q == S_IDLE && start_go) begin
			lbl_wr.we = 1'b1;
		end else if (state_q == S_EB && better) begin
			lbl_wr.we    = 1'b1;
			lbl_wr.addr  = j_q;
			lbl_wr.label = cand;
			lbl_wr.pred  = i_q;
		end
	end

	csplit_tables #(
		.DIST_BITS(DIST_BITS)
	) u_tables (
		.clk     (clk),
		.wr_en   (in_acc),
		.wr_data (in_data),
		.rd      (tbl_rd),
		.dist_rd (dist_rd),
		.dem_rd  (dem_rd),
		.tour_rd (tour_rd)
	);

	csplit_labels u_labels (
		.clk      (clk),
		.wr       (lbl_wr),
		.ra       (lbl_ra),
		.label_rd (label_rd),
		.pred_rd  (pred_rd)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_clients_q <= NODE_W'(1);
			capacity_q    <= {CAP_W{1'b1}};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_CLIENTS: num_clients_q <= cfg_data[NODE_W-1:0];
				REG_CAPACITY:    capacity_q    <= cfg_data[CAP_W-1:0];
				default: ;
			endcase
		end
	end

	// split sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			reached_q   <= '0;
			cut_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start_go) begin
						n_q       <= n_eff;
						i_q       <= '0;
						reached_q <= NODES'(1);
						cut_q     <= '0;
						state_q   <= S_OA;
					end
				end
				S_OA: begin
					j_q     <= i_q + 1'b1;
					state_q <= S_OB;
				end
				S_OB: begin
					c_q     <= tour_rd;
					li_q    <= label_rd;
					state_q <= S_OC;
				end
				S_OC: begin
					path_q  <= dist_ext;
					load_q  <= LOAD_W'(dem_rd);
					state_q <= S_EA;
				end
				S_EA: begin
					pd_q    <= sat_add24(path_q, dist_ext);
					state_q <= S_EB;
				end
				S_EB: begin
					if (better) begin
						reached_q[j_q] <= 1'b1;
					end
					// trip reached the tour end: move to the next start, or to the backtrack after the last one
					if (j_q >= n_q) begin
						if (i_q + 1'b1 == n_q) begin
							p_q     <= n_q;
							state_q <= S_BA;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_OA;
						end
					end else begin
						state_q <= S_XA;
					end
				end
				S_XA: begin
					nc_q    <= tour_rd;
					state_q <= S_XB;
				end
				S_XB: begin
					if (load_next >= LOAD_W'(capacity_q)) begin
						// capacity closes the trip
						if (i_q + 1'b1 == n_q) begin
							p_q     <= n_q;
							state_q <= S_BA;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_OA;
						end
					end else begin
						path_q  <= sat_add24(path_q, dist_ext);
						load_q  <= load_next;
						c_q     <= nc_q;
						j_q     <= j_q + 1'b1;
						state_q <= S_EA;
					end
				end
				S_BA: state_q <= S_BB;
				S_BB: begin
					if (p_q == n_q) begin
						total_q <= label_rd;
					end
					cut_q[p_q] <= 1'b1;
					p_q        <= q_fix;
					if (q_fix == '0) begin
						pos_q    <= NODE_W'(1);
						tstart_q <= 1'b1;
						tidx_q   <= '0;
						state_q  <= S_FA;
					end else begin
						state_q <= S_BA;
					end
				end
				S_FA: state_q <= S_FB;
				S_FB: begin
					c_q     <= tour_rd;
					state_q <= S_FC;
				end
				S_FC: begin
					acc_q    <= tstart_q ? dist_ext : sat_add24(acc_q, dist_ext);
					tstart_q <= 1'b0;
					if (tstart_q) begin
						first_q <= pos_q;
					end
					prev_q <= c_q;
					if (cut_q[pos_q]) begin
						state_q <= S_FD;
					end else begin
						pos_q   <= pos_q + 1'b1;
						state_q <= S_FA;
					end
				end
				S_FD: begin
					out_q.trip_index <= tidx_q;
					out_q.first_pos  <= first_q;
					out_q.last_pos   <= pos_q;
					out_q.trip_cost  <= sat_add24(acc_q, dist_ext);
					out_q.total_cost <= total_q;
					out_q.is_last    <= (pos_q == n_q);
					out_valid_q      <= 1'b1;
					state_q          <= S_OUT;
				end
				S_OUT: begin
					// hold the beat until the sink takes it
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (out_q.is_last) begin
							state_q <= S_IDLE;
						end else begin
							tidx_q   <= tidx_q + 1'b1;
							pos_q    <= pos_q + 1'b1;
							tstart_q <= 1'b1;
							state_q  <= S_FA;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a result beat is only shown while the sequencer waits on the sink
	a_out_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q == S_OUT)
		else $error("result beat outside output wait");

	// every position on the backtrack chain was given a label by the pass
	a_chain_reached: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BB |-> reached_q[p_q])
		else $error("backtrack hit an unlabeled position");

	// a candidate always lies after its start and within the tour
	a_cand_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EB |-> (j_q > i_q && j_q <= n_q))
		else $error("candidate end position out of range");

	// the final beat closes the tour at position n
	a_last_at_n: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.is_last) |-> out_q.last_pos == n_q)
		else $error("final trip does not end at the last position");

endmodule
